// File: rtl/modular_inverse_ext_euclid_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MIE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/mie_pkg.sv
`default_nettype none
package mie_pkg;
    localparam int WORD_BITS = 32;
    localparam int COEF_W    = WORD_BITS + 1;
    localparam int CNT_W     = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                 qbit;
        logic [WORD_BITS-1:0] pr;
        logic [COEF_W-1:0]    acc;
    } t_step;
endpackage
`default_nettype wire

// File: rtl/modular_inverse_ext_euclid.sv
// Sequence: S_IDLE accepts start, S_CHECK loads the divider, then each Euclid step runs a
// bit-serial restoring divide in S_DIV followed by an update in S_UPD (at most about 46 steps
// for 32-bit operands); S_FIN computes the inverse, registered together with the o_valid strobe.
// One transaction at a time; busy falls in the strobe cycle, so a new start can be accepted
// while o_valid is high. The receiver cannot stall the block.
// Reset: synchronous, active low; returns the sequencer to idle and clears the strobe.
`default_nettype none
`include "modular_inverse_ext_euclid_macros.svh"
module modular_inverse_ext_euclid (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mie_pkg::WORD_BITS-1:0] i_value,
    input  wire logic [mie_pkg::WORD_BITS-1:0] i_modulus,
    output logic                               o_valid,
    output logic [mie_pkg::WORD_BITS-1:0]      o_inverse_out
);
    localparam int W = mie_pkg::WORD_BITS;
    localparam int C = mie_pkg::COEF_W;
    localparam int N = mie_pkg::CNT_W;

    mie_pkg::t_state r_state, n_state;
    logic [W-1:0] r_r, n_r, r_nr, n_nr, r_mod, n_mod, r_pr, n_pr, r_dvd, n_dvd;
    logic [C-1:0] r_t, n_t, r_nt, n_nt, r_acc, n_acc;
    logic [N-1:0] r_cnt, n_cnt;
    logic         r_valid, n_valid;
    logic [W-1:0] r_inv, n_inv;
    mie_pkg::t_step step;

    mie_step u_step (
        .i_pr      (r_pr),
        .i_dvd_bit (r_dvd[W-1]),
        .i_nr      (r_nr),
        .i_acc     (r_acc),
        .i_nt      (r_nt),
        .o_step    (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mie_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
        r_r   <= n_r;
        r_nr  <= n_nr;
        r_mod <= n_mod;
        r_pr  <= n_pr;
        r_dvd <= n_dvd;
        r_t   <= n_t;
        r_nt  <= n_nt;
        r_acc <= n_acc;
        r_inv <= n_inv;
    end

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_nr    = r_nr;
        n_mod   = r_mod;
        n_pr    = r_pr;
        n_dvd   = r_dvd;
        n_t     = r_t;
        n_nt    = r_nt;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_inv   = r_inv;
        unique case (r_state)
            mie_pkg::S_IDLE: begin
                if (start) begin
                    n_r     = i_modulus;
                    n_nr    = i_value;
                    n_mod   = i_modulus;
                    n_t     = '0;
                    n_nt    = C'(1);
                    n_state = mie_pkg::S_CHECK;
                end
            end
            mie_pkg::S_CHECK: begin
                n_pr  = '0;
                n_dvd = r_r;
                n_acc = '0;
                n_cnt = '0;
                n_state = (r_nr == '0) ? mie_pkg::S_FIN : mie_pkg::S_DIV;
            end
            mie_pkg::S_DIV: begin
                n_pr  = step.pr;
                n_acc = step.acc;
                n_dvd = {r_dvd[W-2:0], 1'b0};
                n_cnt = r_cnt + N'(1);
                if (r_cnt == N'(W - 1)) begin
                    n_state = mie_pkg::S_UPD;
                end
            end
            mie_pkg::S_UPD: begin
                n_r   = r_nr;
                n_nr  = r_pr;
                n_t   = r_nt;
                n_nt  = r_t - r_acc;
                n_dvd = r_nr;
                n_pr  = '0;
                n_acc = '0;
                n_cnt = '0;
                n_state = (r_pr == '0) ? mie_pkg::S_FIN : mie_pkg::S_DIV;
            end
            mie_pkg::S_FIN: begin
                n_inv   = r_t[C-1] ? (r_t[W-1:0] + r_mod) : r_t[W-1:0];
                n_valid = 1'b1;
                n_state = mie_pkg::S_IDLE;
            end
            default: begin
                n_state = mie_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != mie_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_inverse_out = r_inv;

    `MIE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `MIE_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == mie_pkg::S_DIV, r_nr != '0)
    `MIE_ASSERT_IMPL(a_upd_after_div, i_clk, i_rst_n, r_state == mie_pkg::S_UPD,
                     $past(r_state) == mie_pkg::S_DIV)
    `MIE_ASSERT_IMPL(a_valid_after_fin, i_clk, i_rst_n, o_valid,
                     !busy && $past(r_state) == mie_pkg::S_FIN)
endmodule
`default_nettype wire

// File: rtl/mie_step.sv
`default_nettype none
// One radix-2 step of the restoring division r / nr, with the quotient bit
// folded at once into the running product q * nt.
module mie_step (
    input  wire logic [mie_pkg::WORD_BITS-1:0] i_pr,
    input  wire logic                          i_dvd_bit,
    input  wire logic [mie_pkg::WORD_BITS-1:0] i_nr,
    input  wire logic [mie_pkg::COEF_W-1:0]    i_acc,
    input  wire logic [mie_pkg::COEF_W-1:0]    i_nt,
    output mie_pkg::t_step                     o_step
);
    logic [mie_pkg::WORD_BITS:0] trial;
    logic [mie_pkg::WORD_BITS:0] diff;
    logic [mie_pkg::COEF_W-1:0]  acc_sh;

    always_comb begin
        trial = {i_pr, i_dvd_bit};
        diff  = trial - {1'b0, i_nr};
        o_step.qbit = ~diff[mie_pkg::WORD_BITS];
        o_step.pr   = o_step.qbit ? diff[mie_pkg::WORD_BITS-1:0]
                                  : trial[mie_pkg::WORD_BITS-1:0];
        acc_sh      = {i_acc[mie_pkg::COEF_W-2:0], 1'b0};
        o_step.acc  = o_step.qbit ? (acc_sh + i_nt) : acc_sh;
    end
endmodule
`default_nettype wire
